/* rtl/decision_table_rule_matcher_defines.svh */
// Assertion macros shared by the RTL.
`ifndef DECISION_TABLE_RULE_MATCHER_DEFINES_SVH
`define DECISION_TABLE_RULE_MATCHER_DEFINES_SVH
`ifndef SYNTHESIS
`define DTRM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("dtrm assertion failed");
`define DTRM_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("dtrm forbidden condition");
`else
`define DTRM_ASSERT(lbl, clk, rstn, prop)
`define DTRM_NEVER(lbl, clk, rstn, expr)
`endif
`endif

/* rtl/dtrm_pkg.sv */
`timescale 1ns / 1ps
package dtrm_pkg;
  localparam int COND_SLOTS = 64;
  localparam int RULES      = 32;
  localparam int TERMS      = 8;
  localparam int MAX_OUT    = 32;

  localparam int SAW = (COND_SLOTS > 1) ? $clog2(COND_SLOTS) : 1;
  localparam int RW  = $clog2(RULES + 1);
  localparam int RAW = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int TW  = $clog2(TERMS + 1);
  localparam int TAW = (RULES * TERMS > 1) ? $clog2(RULES * TERMS) : 1;
  localparam int KW  = $clog2(MAX_OUT + 1);
  localparam int KAW = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_SET   = 2'd1;
  localparam logic [1:0] FUNC_ADD   = 2'd2;
  localparam logic [1:0] FUNC_EVAL  = 2'd3;

  localparam logic [1:0] KIND_DONE  = 2'd0;
  localparam logic [1:0] KIND_FIRE  = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;
  localparam logic [1:0] KIND_FULL  = 2'd3;

  typedef struct packed {
    logic       load;
    logic       clr;
    logic       scan_init;
    logic       idx_inc;
    logic       note_slot;
    logic       set_wr;
    logic       open;
    logic       t_clr;
    logic       t_inc;
    logic       tw_upd;
    logic       tw_new;
    logic       add_close;
    logic       r_clr;
    logic       r_inc;
    logic       tload;
    logic       j_clr;
    logic       j_inc;
    logic       e_add;
    logic       emit;
    logic [1:0] kind;
    logic       use_pend;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       has_term;
    logic       term_last;
    logic       building;
    logic       rules_full;
    logic       hit;
    logic       idx_last;
    logic       slot_ok;
    logic       n_zero;
    logic       n_full;
    logic       t_end;
    logic       t_next_end;
    logic       term_hit;
    logic       val_match;
    logic       r_end;
    logic       k_full;
    logic       k_zero;
    logic       j_end;
    logic       dup;
  } sts_t;
endpackage

/* rtl/dtrm_ctrl.sv */
`timescale 1ns / 1ps
module dtrm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  dtrm_pkg::sts_t sts_i,
  output dtrm_pkg::cmd_t cmd_o,
  output logic           busy_o
);
  import dtrm_pkg::*;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_DISP  = 5'd1;
  localparam logic [4:0] ST_S_RD  = 5'd2;
  localparam logic [4:0] ST_S_CMP = 5'd3;
  localparam logic [4:0] ST_S_WR  = 5'd4;
  localparam logic [4:0] ST_A_TC  = 5'd5;
  localparam logic [4:0] ST_A_RD  = 5'd6;
  localparam logic [4:0] ST_A_CMP = 5'd7;
  localparam logic [4:0] ST_A_NEW = 5'd8;
  localparam logic [4:0] ST_A_END = 5'd9;
  localparam logic [4:0] ST_A_ENF = 5'd10;
  localparam logic [4:0] ST_E_RUL = 5'd11;
  localparam logic [4:0] ST_E_TRM = 5'd12;
  localparam logic [4:0] ST_E_TRD = 5'd13;
  localparam logic [4:0] ST_E_TLD = 5'd14;
  localparam logic [4:0] ST_E_SRD = 5'd15;
  localparam logic [4:0] ST_E_SCM = 5'd16;
  localparam logic [4:0] ST_E_DUP = 5'd17;
  localparam logic [4:0] ST_E_ADD = 5'd18;
  localparam logic [4:0] ST_E_END = 5'd19;

  logic [4:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISP;
        end
      end
      ST_DISP: begin
        case (sts_i.func)
          FUNC_CLEAR: begin
            cmd_o.clr  = 1'b1;
            cmd_o.emit = 1'b1;
            cmd_o.kind = KIND_DONE;
            cmd_o.last = 1'b1;
            state_d    = ST_IDLE;
          end
          FUNC_SET: begin
            cmd_o.scan_init = 1'b1;
            state_d         = ST_S_RD;
          end
          FUNC_ADD: begin
            if (!sts_i.building && sts_i.rules_full) begin
              cmd_o.emit = 1'b1;
              cmd_o.kind = KIND_FULL;
              cmd_o.last = 1'b1;
              state_d    = ST_IDLE;
            end else begin
              cmd_o.open = !sts_i.building;
              state_d    = ST_A_TC;
            end
          end
          default: begin
            cmd_o.r_clr = 1'b1;
            state_d     = ST_E_RUL;
          end
        endcase
      end
      ST_S_RD: state_d = ST_S_CMP;
      ST_S_CMP: begin
        cmd_o.note_slot = 1'b1;
        if (sts_i.hit || sts_i.idx_last) begin
          state_d = ST_S_WR;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = ST_S_RD;
        end
      end
      ST_S_WR: begin
        cmd_o.set_wr = sts_i.slot_ok;
        cmd_o.emit   = 1'b1;
        cmd_o.kind   = sts_i.slot_ok ? KIND_DONE : KIND_FULL;
        cmd_o.last   = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_A_TC: begin
        cmd_o.t_clr = 1'b1;
        if (!sts_i.has_term) begin
          state_d = ST_A_END;
        end else if (sts_i.n_zero) begin
          state_d = ST_A_NEW;
        end else begin
          state_d = ST_A_RD;
        end
      end
      ST_A_RD: state_d = ST_A_CMP;
      ST_A_CMP: begin
        if (sts_i.term_hit) begin
          cmd_o.tw_upd = 1'b1;
          state_d      = ST_A_END;
        end else begin
          cmd_o.t_inc = 1'b1;
          state_d     = sts_i.t_next_end ? ST_A_NEW : ST_A_RD;
        end
      end
      ST_A_NEW: begin
        if (sts_i.n_full) begin
          state_d = ST_A_ENF;
        end else begin
          cmd_o.tw_new = 1'b1;
          state_d      = ST_A_END;
        end
      end
      ST_A_END, ST_A_ENF: begin
        cmd_o.add_close = sts_i.term_last;
        cmd_o.emit      = 1'b1;
        cmd_o.kind      = (state_q == ST_A_ENF) ? KIND_FULL : KIND_DONE;
        cmd_o.last      = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_E_RUL: begin
        cmd_o.t_clr = 1'b1;
        state_d     = (sts_i.r_end || sts_i.k_full) ? ST_E_END : ST_E_TRM;
      end
      ST_E_TRM: begin
        if (sts_i.t_end) begin
          cmd_o.j_clr = 1'b1;
          state_d     = ST_E_DUP;
        end else begin
          state_d = ST_E_TRD;
        end
      end
      ST_E_TRD: state_d = ST_E_TLD;
      ST_E_TLD: begin
        cmd_o.tload     = 1'b1;
        cmd_o.scan_init = 1'b1;
        state_d         = ST_E_SRD;
      end
      ST_E_SRD: state_d = ST_E_SCM;
      ST_E_SCM: begin
        if (sts_i.hit) begin
          if (sts_i.val_match) begin
            cmd_o.t_inc = 1'b1;
            state_d     = ST_E_TRM;
          end else begin
            cmd_o.r_inc = 1'b1;
            state_d     = ST_E_RUL;
          end
        end else if (sts_i.idx_last) begin
          cmd_o.r_inc = 1'b1;
          state_d     = ST_E_RUL;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = ST_E_SRD;
        end
      end
      ST_E_DUP: begin
        if (sts_i.j_end) begin
          state_d = ST_E_ADD;
        end else if (sts_i.dup) begin
          cmd_o.r_inc = 1'b1;
          state_d     = ST_E_RUL;
        end else begin
          cmd_o.j_inc = 1'b1;
        end
      end
      ST_E_ADD: begin
        cmd_o.e_add    = 1'b1;
        cmd_o.r_inc    = 1'b1;
        cmd_o.emit     = !sts_i.k_zero;
        cmd_o.kind     = KIND_FIRE;
        cmd_o.use_pend = 1'b1;
        state_d        = ST_E_RUL;
      end
      ST_E_END: begin
        cmd_o.emit     = 1'b1;
        cmd_o.kind     = sts_i.k_zero ? KIND_NONE : KIND_FIRE;
        cmd_o.use_pend = !sts_i.k_zero;
        cmd_o.last     = 1'b1;
        state_d        = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

/* rtl/dtrm_dp.sv */
`timescale 1ns / 1ps
module dtrm_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dtrm_pkg::cmd_t cmd_i,
  output dtrm_pkg::sts_t sts_o,
  input  logic [1:0]     func_i,
  input  logic [63:0]    cond_key_i,
  input  logic           cond_value_i,
  input  logic [63:0]    rule_action_i,
  input  logic           has_term_i,
  input  logic           term_last_i,
  output logic           valid_o,
  output logic [1:0]     kind_o,
  output logic [63:0]    fired_action_o,
  output logic           last_o
);
  import dtrm_pkg::*;

  logic [64:0]     kmem [COND_SLOTS];
  logic [64:0]     tmem [RULES*TERMS];
  logic [COND_SLOTS-1:0] kvalid_q;
  logic [63:0]     rule_id_q [RULES];
  logic [TW-1:0]   tcount_q [RULES];
  logic [63:0]     outbuf_q [MAX_OUT];

  logic [1:0]      func_q;
  logic [63:0]     key_q, act_q, tkey_q, pend_q;
  logic            val_q, has_q, tlast_q, tneed_q;
  logic [RW-1:0]   rule_count_q, r_q, rsel;
  logic            building_q;
  logic [SAW-1:0]  idx_q, fidx_q, free_idx_q;
  logic            found_q, free_found_q;
  logic [TW-1:0]   t_q, n;
  logic [KW-1:0]   k_q, j_q;
  logic [64:0]     krd_q, trd_q;
  logic            vrd_q;
  logic [TAW-1:0]  taddr;
  logic [63:0]     scan_key, rid;
  logic            valid_q, last_q;
  logic [1:0]      kind_q;
  logic [63:0]     fact_q;

  assign rsel     = (func_q == FUNC_EVAL) ? r_q : rule_count_q;
  assign n        = tcount_q[rsel[RAW-1:0]];
  assign rid      = rule_id_q[rsel[RAW-1:0]];
  assign taddr    = TAW'(32'(rsel) * TERMS + 32'(t_q));
  assign scan_key = (func_q == FUNC_EVAL) ? tkey_q : key_q;

  always_ff @(posedge clk_i) begin
    krd_q <= kmem[idx_q];
    vrd_q <= kvalid_q[idx_q];
    trd_q <= tmem[taddr];
    if (cmd_i.set_wr) begin
      kmem[found_q ? fidx_q : free_idx_q] <= {key_q, val_q};
    end
    if (cmd_i.tw_upd || cmd_i.tw_new) begin
      tmem[taddr] <= {key_q, val_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_i;
      key_q   <= cond_key_i;
      val_q   <= cond_value_i;
      act_q   <= rule_action_i;
      has_q   <= has_term_i;
      tlast_q <= term_last_i;
    end
    if (cmd_i.scan_init) begin
      idx_q        <= '0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + 1'b1;
    end
    if (cmd_i.note_slot) begin
      if (vrd_q && krd_q[64:1] == scan_key) begin
        found_q <= 1'b1;
        fidx_q  <= idx_q;
      end
      if (!vrd_q && !free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= idx_q;
      end
    end
    if (cmd_i.open) begin
      rule_id_q[rule_count_q[RAW-1:0]] <= act_q;
      tcount_q[rule_count_q[RAW-1:0]]  <= '0;
    end else if (cmd_i.tw_new) begin
      tcount_q[rsel[RAW-1:0]] <= n + 1'b1;
    end
    if (cmd_i.t_clr) begin
      t_q <= '0;
    end else if (cmd_i.t_inc) begin
      t_q <= t_q + 1'b1;
    end
    if (cmd_i.tload) begin
      tkey_q  <= trd_q[64:1];
      tneed_q <= trd_q[0];
    end
    if (cmd_i.r_clr) begin
      r_q <= '0;
      k_q <= '0;
    end else begin
      if (cmd_i.r_inc) r_q <= r_q + 1'b1;
      if (cmd_i.e_add) k_q <= k_q + 1'b1;
    end
    if (cmd_i.j_clr) begin
      j_q <= '0;
    end else if (cmd_i.j_inc) begin
      j_q <= j_q + 1'b1;
    end
    if (cmd_i.e_add) begin
      outbuf_q[k_q[KAW-1:0]] <= rid;
      pend_q                 <= rid;
    end
    if (cmd_i.emit) begin
      kind_q <= cmd_i.kind;
      fact_q <= cmd_i.use_pend ? pend_q : 64'd0;
      last_q <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kvalid_q     <= '0;
      rule_count_q <= '0;
      building_q   <= 1'b0;
      valid_q      <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
      if (cmd_i.clr) begin
        kvalid_q     <= '0;
        rule_count_q <= '0;
        building_q   <= 1'b0;
      end else begin
        if (cmd_i.set_wr) kvalid_q[found_q ? fidx_q : free_idx_q] <= 1'b1;
        if (cmd_i.open) building_q <= 1'b1;
        if (cmd_i.add_close) begin
          building_q   <= 1'b0;
          rule_count_q <= rule_count_q + 1'b1;
        end
      end
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.func       = func_q;
    sts_o.has_term   = has_q;
    sts_o.term_last  = tlast_q;
    sts_o.building   = building_q;
    sts_o.rules_full = (rule_count_q >= RW'(RULES));
    sts_o.hit        = vrd_q && (krd_q[64:1] == scan_key);
    sts_o.idx_last   = (idx_q == SAW'(COND_SLOTS - 1));
    sts_o.slot_ok    = found_q || free_found_q;
    sts_o.n_zero     = (n == '0);
    sts_o.n_full     = (n == TW'(TERMS));
    sts_o.t_end      = (t_q == n);
    sts_o.t_next_end = (TW'(t_q + 1'b1) == n);
    sts_o.term_hit   = (trd_q[64:1] == key_q);
    sts_o.val_match  = (krd_q[0] == tneed_q);
    sts_o.r_end      = (r_q == rule_count_q);
    sts_o.k_full     = (k_q == KW'(MAX_OUT));
    sts_o.k_zero     = (k_q == '0);
    sts_o.j_end      = (j_q == k_q);
    sts_o.dup        = (outbuf_q[j_q[KAW-1:0]] == rid);
  end

  assign valid_o        = valid_q;
  assign kind_o         = kind_q;
  assign fired_action_o = fact_q;
  assign last_o         = last_q;
endmodule

/* rtl/decision_table_rule_matcher.sv */
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// command   start / busy         func, cond_key, cond_value, rule_action, has_term, term_last
// result    valid_o strobe       kind, fired_action, last
// Clear needs no search; set condition runs a search of the condition slots.
// Add term runs a term search of the open rule.
// Evaluate runs, for every rule and every term, a search of the condition memory
// that reads each slot and compares it before it moves on to the next slot.
// Reset is asynchronous, active low; stores are not swept, valid bits clear at once.
// Results come in the cycle after they are found; the receiver cannot stall.
module decision_table_rule_matcher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [63:0] cond_key_i,
  input  logic        cond_value_i,
  input  logic [63:0] rule_action_i,
  input  logic        has_term_i,
  input  logic        term_last_i,
  output logic        valid_o,
  output logic [1:0]  kind_o,
  output logic [63:0] fired_action_o,
  output logic        last_o
);
  import dtrm_pkg::*;
  `include "decision_table_rule_matcher_defines.svh"

  cmd_t cmd;
  sts_t sts;

  dtrm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  dtrm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .func_i        (func_i),
    .cond_key_i    (cond_key_i),
    .cond_value_i  (cond_value_i),
    .rule_action_i (rule_action_i),
    .has_term_i    (has_term_i),
    .term_last_i   (term_last_i),
    .valid_o       (valid_o),
    .kind_o        (kind_o),
    .fired_action_o(fired_action_o),
    .last_o        (last_o)
  );

  `DTRM_ASSERT(a_last_idle, clk_i, rst_ni, valid_o && last_o |-> !busy)
  `DTRM_ASSERT(a_accept_busy, clk_i, rst_ni, start && !busy |=> busy && !valid_o)
  `DTRM_ASSERT(a_single_last, clk_i, rst_ni, valid_o && kind_o != KIND_FIRE |-> last_o)
  `DTRM_NEVER(a_zero_action, clk_i, rst_ni,
              valid_o && kind_o != KIND_FIRE && fired_action_o != 64'd0)
endmodule
